// File: design/bounded_queue_with_indexed_remove_defines.svh
// Assertion macros shared by the queue RTL.
`ifndef BOUNDED_QUEUE_WITH_INDEXED_REMOVE_DEFINES_SVH
`define BOUNDED_QUEUE_WITH_INDEXED_REMOVE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define BQIR_ASSERT_NOW(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("bqir assertion failed");

// Next-cycle implication, disabled during reset.
`define BQIR_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("bqir assertion failed");

`else

`define BQIR_ASSERT_NOW(label, clk, rst_n, lhs, rhs)
`define BQIR_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

// File: design/bqir_pkg.sv
// Shared types and constants for the bounded queue with indexed remove.
`timescale 1ns / 1ps
`default_nettype none

package bqir_pkg;

    localparam int MODE_W   = 2;
    localparam int ENTRY_W  = 16;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    localparam int DEFAULT_DEPTH        = 32;
    localparam int DEFAULT_HANDLE_WIDTH = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_REMOVE = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

endpackage

`default_nettype wire

// File: design/bounded_queue_with_indexed_remove.sv
// Bounded queue with push, pop and remove-at-index; 1 item/cycle when not stalled.
// Pipeline: an input transfer lands in the input register, then the queue update
// runs and loads the result register, which holds while out_stall is asserted.
// Throughput: one item per cycle while out_stall is low, set by the update of the shifting
// register array. Reset clears occupancy and all valid flags; slots are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_queue_with_indexed_remove_defines.svh"

module bounded_queue_with_indexed_remove #(
    parameter int DEPTH        = bqir_pkg::DEFAULT_DEPTH,
    parameter int HANDLE_WIDTH = bqir_pkg::DEFAULT_HANDLE_WIDTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [bqir_pkg::MODE_W-1:0]   mode,
    input  wire logic [bqir_pkg::ENTRY_W-1:0]  entry_in,
    input  wire logic [bqir_pkg::POS_W-1:0]    position_in,

    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [bqir_pkg::STATUS_W-1:0]      status,
    output logic [bqir_pkg::POS_W-1:0]         position_out,
    output logic [bqir_pkg::ENTRY_W-1:0]       entry_out,
    output logic [bqir_pkg::COUNT_W-1:0]       count
);

    import bqir_pkg::*;

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (OCC_W > POS_W) ? OCC_W : POS_W;

    typedef logic [HANDLE_WIDTH-1:0] slot_t;

    // input register
    logic                in_valid_reg;
    logic [MODE_W-1:0]   mode_reg;
    slot_t               entry_reg;
    logic [POS_W-1:0]    pos_reg;

    // queue state
    slot_t               slots_reg [DEPTH];
    logic [OCC_W-1:0]    occ_reg;
    logic [OCC_W-1:0]    occ_next;

    // result register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [POS_W-1:0]    pos_out_reg;
    logic [ENTRY_W-1:0]  entry_out_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic                fire;
    logic                do_push;
    logic                do_take;
    status_t             st_next;
    logic [POS_W-1:0]    pos_out_next;
    logic [ENTRY_W-1:0]  entry_out_next;
    logic [POS_W-1:0]    take_idx;
    logic [CMP_W-1:0]    take_idx_ext;
    logic [CMP_W-1:0]    occ_ext;

    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            mode_reg  <= mode;
            entry_reg <= slot_t'(entry_in);
            pos_reg   <= position_in;
        end
    end

    // pop is a remove at the head
    assign take_idx     = (mode_t'(mode_reg) == MODE_POP) ? '0 : pos_reg;
    assign take_idx_ext = CMP_W'(take_idx);
    assign occ_ext      = CMP_W'(occ_reg);

    always_comb
    begin
        st_next        = ST_MISSING;
        pos_out_next   = '0;
        entry_out_next = '0;
        occ_next       = occ_reg;
        do_push        = 1'b0;
        do_take        = 1'b0;
        case (mode_t'(mode_reg))
            MODE_PUSH:
            begin
                if (occ_reg >= OCC_W'(DEPTH))
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    st_next      = ST_OK;
                    do_push      = 1'b1;
                    pos_out_next = POS_W'(occ_reg);
                    occ_next     = occ_reg + OCC_W'(1);
                end
            end
            MODE_POP, MODE_REMOVE:
            begin
                if (take_idx_ext < occ_ext)
                begin
                    st_next        = ST_OK;
                    do_take        = 1'b1;
                    entry_out_next = ENTRY_W'(slots_reg[IDX_W'(take_idx)]);
                    occ_next       = occ_reg - OCC_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (fire)
        begin
            occ_reg <= occ_next;
        end
    end

    // each cell either takes the push, shifts in its upper neighbor, or holds
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        always_ff @(posedge clk)
        begin
            if (fire && do_push && (IDX_W'(occ_reg) == IDX_W'(g)))
            begin
                slots_reg[g] <= entry_reg;
            end
            else if (fire && do_take && (CMP_W'(g) >= take_idx_ext))
            begin
                if (g < DEPTH - 1)
                begin
                    slots_reg[g] <= slots_reg[(g < DEPTH - 1) ? g + 1 : g];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg    <= st_next;
            pos_out_reg   <= pos_out_next;
            entry_out_reg <= entry_out_next;
            count_reg     <= COUNT_W'(occ_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign position_out = pos_out_reg;
    assign entry_out    = entry_out_reg;
    assign count        = count_reg;

    `BQIR_ASSERT_NEXT(a_push_grows, clk, rst_n, fire && do_push, occ_reg == $past(occ_reg) + OCC_W'(1))
    `BQIR_ASSERT_NEXT(a_take_shrinks, clk, rst_n, fire && do_take, occ_reg == $past(occ_reg) - OCC_W'(1))
    `BQIR_ASSERT_NEXT(a_fail_holds, clk, rst_n, fire && !do_push && !do_take, $stable(occ_reg))
    `BQIR_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, in_valid_reg && out_valid_reg && out_stall)
    `BQIR_ASSERT_NEXT(a_fire_result, clk, rst_n, fire, out_valid && (count == COUNT_W'(occ_reg)))

endmodule

`default_nettype wire
